// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FBA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FBA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/fba_pkg.sv -----
package fba_pkg;

	localparam int ADDR_W     = 32;
	localparam int PAGE_SHIFT = 12;
	localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
	localparam int FRAME_W    = 12;
	localparam int CNT_W      = 13;
	localparam logic [CNT_W-1:0] CNT_RESET = 13'd4095;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_MAPPED = 2'd1;
	localparam status_t ST_FULL   = 2'd2;
	localparam status_t ST_RANGE  = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_MARK  = 1'b1;

	typedef struct packed {
		logic    clear_step;
		logic    accept;
		logic    scan_step;
		logic    mark_step;
		logic    mark_write;
		logic    load_res;
		status_t res_status;
	} fba_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic kind;
		logic has_frame;
		logic range_err;
		logic scan_hit;
		logic scan_full;
		logic mark_found;
		logic out_busy;
	} fba_sts_t;

endpackage

// ----- hdl/fba_ctrl.sv -----
module fba_ctrl
	import fba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  fba_sts_t sts,
	output fba_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_LOCATE,
		S_MARK_WR,
		S_FINISH
	} state_t;

	state_t  state_q;
	status_t res_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.res_status = res_q;
		case (state_q)
			S_CLEAR:   cmd.clear_step = 1'b1;
			S_IDLE:    cmd.accept     = in_valid;
			S_SCAN:    cmd.scan_step  = 1'b1;
			S_LOCATE:  cmd.mark_step  = 1'b1;
			S_MARK_WR: cmd.mark_write = 1'b1;
			S_FINISH:  cmd.load_res   = !sts.out_busy;
			default:   cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= ST_OK;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clear_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.kind == KIND_ALLOC) begin
						if (sts.has_frame) begin
							res_q   <= ST_MAPPED;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (sts.range_err) begin
						res_q   <= ST_RANGE;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_LOCATE;
					end
				end
				S_SCAN: begin
					if (sts.scan_hit) begin
						res_q   <= ST_OK;
						state_q <= S_FINISH;
					end else if (sts.scan_full) begin
						res_q   <= ST_FULL;
						state_q <= S_FINISH;
					end
				end
				S_LOCATE: begin
					if (sts.mark_found) state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					res_q   <= ST_OK;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!sts.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/fba_dpath.sv -----
module fba_dpath
	import fba_pkg::*;
#(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fba_cmd_t           cmd,
	output fba_sts_t           sts,
	input  logic               kind,
	input  logic [ADDR_W-1:0]  phys_address,
	input  logic               entry_has_frame,
	input  logic               kernel_page,
	input  logic               writable,
	input  logic               cfg_valid,
	input  logic [CNT_W-1:0]   cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output status_t            status,
	output logic [FRAME_W-1:0] frame_number,
	output logic               page_present,
	output logic               page_writable,
	output logic               page_user
);

	localparam int DEPTH = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int CW    = $clog2(MAX_FRAMES + 1);
	localparam int BW    = $clog2(MAX_FRAMES + WORD_BITS + 1);

	logic [WORD_BITS-1:0] mem [DEPTH];

	logic [CNT_W-1:0]     count_q;
	logic [CW-1:0]        eff_count;
	logic [AW-1:0]        addr_q;
	logic [BW-1:0]        base_q;
	logic                 rd_pend_s1;
	logic                 out_valid_q;

	logic                 kind_q;
	logic                 has_frame_q;
	logic                 kernel_q;
	logic                 writable_q;
	logic [PFN_W-1:0]     frame_q;
	logic [AW-1:0]        addr_s1;
	logic [BW-1:0]        base_s1;
	logic [BIT_W-1:0]     bit_q;
	logic [WORD_BITS-1:0] rd_data_s1;

	logic                 in_lim;
	logic                 rd_en;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [BIT_W-1:0]     zero_idx;
	logic                 advance;

	assign eff_count = (32'(count_q) > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(count_q);
	assign in_lim    = (32'(base_q) + 32'(WORD_BITS)) <= 32'(eff_count);

	// lowest clear bit of the word just read
	always_comb begin
		zero_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!rd_data_s1[i]) zero_idx = BIT_W'(i);
		end
	end

	always_comb begin
		sts            = '0;
		sts.clear_last = (addr_q == AW'(DEPTH - 1));
		sts.kind       = kind_q;
		sts.has_frame  = has_frame_q;
		sts.range_err  = 32'(frame_q) >= 32'(eff_count);
		sts.scan_hit   = rd_pend_s1 && !(&rd_data_s1);
		sts.scan_full  = !in_lim && !sts.scan_hit;
		sts.mark_found = 32'(frame_q) < (32'(base_q) + 32'(WORD_BITS));
		sts.out_busy   = out_valid_q && out_stall;
	end

	assign rd_en   = (cmd.scan_step && in_lim) || (cmd.mark_step && sts.mark_found);
	assign advance = (cmd.scan_step && in_lim) || (cmd.mark_step && !sts.mark_found);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = rd_data_s1 | (WORD_BITS'(1) << bit_q);
		if (cmd.clear_step) begin
			wr_en   = 1'b1;
			wr_addr = addr_q;
			wr_data = '0;
		end else if (cmd.scan_step && sts.scan_hit) begin
			wr_en   = 1'b1;
			wr_data = rd_data_s1 | (WORD_BITS'(1) << zero_idx);
		end else if (cmd.mark_write) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_RESET;
			addr_q      <= '0;
			base_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) count_q <= cfg_data;
			rd_pend_s1 <= cmd.scan_step && in_lim;
			if (cmd.accept) begin
				addr_q <= '0;
				base_q <= '0;
			end else if (cmd.clear_step) begin
				addr_q <= addr_q + AW'(1);
			end else if (advance) begin
				addr_q <= addr_q + AW'(1);
				base_q <= base_q + BW'(WORD_BITS);
			end
			if (cmd.load_res) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q      <= kind;
			has_frame_q <= entry_has_frame;
			kernel_q    <= kernel_page;
			writable_q  <= writable;
			frame_q     <= phys_address[ADDR_W-1:PAGE_SHIFT];
		end else if (cmd.scan_step && sts.scan_hit) begin
			frame_q <= PFN_W'(32'(base_s1) + 32'(zero_idx));
		end
		if (rd_en) begin
			addr_s1 <= addr_q;
			base_s1 <= base_q;
			bit_q   <= BIT_W'(32'(frame_q) - 32'(base_q));
		end
		if (cmd.load_res) begin
			status <= cmd.res_status;
			if (cmd.res_status == ST_OK) begin
				frame_number  <= frame_q[FRAME_W-1:0];
				page_present  <= 1'b1;
				page_writable <= writable_q;
				page_user     <= !kernel_q;
			end else begin
				frame_number  <= '0;
				page_present  <= 1'b0;
				page_writable <= 1'b0;
				page_user     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/frame_bitmap_allocator_unit.sv -----
// Bitmap frame allocator: one used/free bit per 4 KiB physical frame.
// Input channel (in_valid/in_stall): kind 0 allocates the lowest free frame,
// kind 1 marks the frame holding phys_address as used. A transfer happens when
// in_valid is high and in_stall is low; one item is worked on at a time.
// Output channel (out_valid/out_stall): one result per item, held in an output
// register, so the next item may start while a result waits to be taken.
// Config channel (cfg_valid/cfg_ready): writes frame_count; always ready.
// Already-mapped and out-of-range items go from accept through CHECK to FINISH,
// where the result is loaded. An allocation scans up to MAX_FRAMES/WORD_BITS
// bitmap words (128 by default), one word read per cycle from bitmap memory,
// and sets the lowest clear bit it finds. A mark steps a word counter up to the
// word of its frame, then reads that word and writes it back with the bit set.
// Reset: the bitmap memory is swept to zero, one word per cycle over all
// MAX_FRAMES/WORD_BITS words (128 by default), with in_stall high.
// While the receiver stalls, a finished result holds in the output register
// and the next result waits in the controller until it is taken.
`include "assert_macros.svh"

module frame_bitmap_allocator_unit
	import fba_pkg::*;
#(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [ADDR_W-1:0]  phys_address,
	input  logic               entry_has_frame,
	input  logic               kernel_page,
	input  logic               writable,
	output logic               out_valid,
	input  logic               out_stall,
	output status_t            status,
	output logic [FRAME_W-1:0] frame_number,
	output logic               page_present,
	output logic               page_writable,
	output logic               page_user,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data
);

	fba_cmd_t cmd;
	fba_sts_t sts;

	assign cfg_ready = 1'b1;

	fba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fba_dpath #(
		.MAX_FRAMES (MAX_FRAMES),
		.WORD_BITS  (WORD_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.phys_address    (phys_address),
		.entry_has_frame (entry_has_frame),
		.kernel_page     (kernel_page),
		.writable        (writable),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_number    (frame_number),
		.page_present    (page_present),
		.page_writable   (page_writable),
		.page_user       (page_user)
	);

	`FBA_ASSERT_IMP(a_stall_in_clear, clk, arst_n, cmd.clear_step, in_stall, "item taken during clear")
	`FBA_ASSERT_NXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall, "second item taken")
	`FBA_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.load_res, !(out_valid && out_stall), "result overwritten")
	`FBA_ASSERT_IMP(a_hit_not_full, clk, arst_n, sts.scan_hit, !sts.scan_full, "scan hit and full together")

endmodule

// ----- verif/frame_grant_checker.sv -----
`timescale 1ns / 100ps

module frame_grant_checker
	import fba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic [ADDR_W-1:0]  phys_address,
	input  logic               entry_has_frame,
	input  logic               kernel_page,
	input  logic               writable,
	input  logic               out_valid,
	input  logic               out_stall,
	input  status_t            status,
	input  logic [FRAME_W-1:0] frame_number,
	input  logic               page_present,
	input  logic               page_writable,
	input  logic               page_user,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CNT_W-1:0]   cfg_data,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int MAP_FRAMES = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = MAP_FRAMES / WORD_BITS;
	localparam int MAP_AW     = $clog2(MAP_WORDS);
	localparam int BIT_AW     = $clog2(WORD_BITS);

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] frame;
		logic               present;
		logic               writable;
		logic               user;
	} grant_t;

	logic [WORD_BITS-1:0] used_map [MAP_WORDS];
	logic [CNT_W-1:0]     frame_limit;
	grant_t               grants_due [$];
	int                   fail_tally;

	function automatic grant_t allocate_or_mark(input logic op, input logic [ADDR_W-1:0] addr,
			input logic has_frame, input logic kern, input logic wr);
		grant_t g;
		int     limit;
		int     frame;
		int     w;
		int     b;
		logic   found;
		g     = '0;
		frame = 0;
		found = 1'b0;
		limit = (frame_limit > MAP_FRAMES) ? MAP_FRAMES : int'(frame_limit);
		g.status = ST_OK;
		if (op == KIND_ALLOC) begin
			if (has_frame) begin
				g.status = ST_MAPPED;
			end else begin
				// search whole words below the count only, lowest clear bit first
				for (w = 0; w < limit / WORD_BITS && !found; w++) begin
					for (b = 0; b < WORD_BITS && !found; b++) begin
						if (!used_map[MAP_AW'(w)][BIT_AW'(b)]) begin
							frame = w * WORD_BITS + b;
							found = 1'b1;
						end
					end
				end
				if (!found)
					g.status = ST_FULL;
			end
		end else begin
			frame = int'(addr >> PAGE_SHIFT);
			if (frame >= limit)
				g.status = ST_RANGE;
		end
		if (g.status == ST_OK) begin
			used_map[MAP_AW'(frame / WORD_BITS)][BIT_AW'(frame % WORD_BITS)] = 1'b1;
			g.frame    = frame[FRAME_W-1:0];
			g.present  = 1'b1;
			g.writable = wr;
			g.user     = ~kern;
		end
		return g;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			foreach (used_map[i])
				used_map[i] = '0;
			frame_limit = CNT_RESET;
			grants_due.delete();
			fail_tally  = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				frame_limit = cfg_data;
			// compare before queuing so a result never meets its own item
			if (out_valid && !out_stall) begin
				if (grants_due.size() == 0) begin
					$error("result with no item waiting: status %0d, frame %0d",
						status, frame_number);
					fail_tally++;
				end else begin
					want = grants_due.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("frame_number", 32'(want.frame), 32'(frame_number));
					check_field("page_present", 32'(want.present), 32'(page_present));
					check_field("page_writable", 32'(want.writable), 32'(page_writable));
					check_field("page_user", 32'(want.user), 32'(page_user));
				end
			end
			if (in_valid && !in_stall)
				grants_due.push_back(allocate_or_mark(kind, phys_address, entry_has_frame,
					kernel_page, writable));
			mismatches  <= fail_tally;
			outstanding <= grants_due.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import fba_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 200;
	localparam int PHASE_ITEMS  = 123;
	localparam int MAP_FRAMES   = 4096;

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_stall;
	logic               kind            = KIND_ALLOC;
	logic [ADDR_W-1:0]  phys_address    = '0;
	logic               entry_has_frame = 1'b0;
	logic               kernel_page     = 1'b0;
	logic               writable        = 1'b0;
	logic               out_valid;
	logic               out_stall       = 1'b0;
	status_t            status;
	logic [FRAME_W-1:0] frame_number;
	logic               page_present;
	logic               page_writable;
	logic               page_user;
	logic               cfg_valid       = 1'b0;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data        = '0;

	int   mismatches;
	int   outstanding;
	int   quiet_cycles = 0;
	int   stall_hold   = 0;
	logic steady_flow  = 1'b0;

	int phase_limits [10] = '{64, 100, 4095, 33, 8191, 0, 4096, -1, 160, 4095};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	frame_bitmap_allocator_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.phys_address    (phys_address),
		.entry_has_frame (entry_has_frame),
		.kernel_page     (kernel_page),
		.writable        (writable),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_number    (frame_number),
		.page_present    (page_present),
		.page_writable   (page_writable),
		.page_user       (page_user),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	frame_grant_checker grant_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.phys_address    (phys_address),
		.entry_has_frame (entry_has_frame),
		.kernel_page     (kernel_page),
		.writable        (writable),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_number    (frame_number),
		.page_present    (page_present),
		.page_writable   (page_writable),
		.page_user       (page_user),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	always @(posedge clk) begin
		if (stall_hold == 0) begin
			if (steady_flow || !arst_n) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(1, 4);
			end else begin
				out_stall  <= 1'($urandom_range(0, 1));
				stall_hold <= gap_len() + 1;
			end
		end else begin
			stall_hold <= stall_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// valid stays high across back-to-back transfers
	task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
			input logic has_frame, input logic kern, input logic wr);
		int gap;
		gap = steady_flow ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		kind            <= op;
		phys_address    <= addr;
		entry_has_frame <= has_frame;
		kernel_page     <= kern;
		writable        <= wr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_limit(input logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(input int limit);
		int                r;
		logic [19:0]       pfn;
		logic [ADDR_W-1:0] addr;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_item(KIND_ALLOC, $urandom, 1'b0, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (r < 55) begin
			send_item(KIND_ALLOC, $urandom, 1'b1, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (r < 88 && limit > 0) begin
			pfn  = 20'($urandom_range(0, limit - 1));
			addr = {pfn, 12'($urandom_range(0, 4095))};
			send_item(KIND_MARK, addr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else begin
			send_item(KIND_MARK, $urandom, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int limit;
		int eff;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset count: the frame at the count's edge is out of range
		send_item(KIND_ALLOC, 32'h0, 1'b1, 1'b1, 1'b1);
		send_item(KIND_ALLOC, 32'h0, 1'b0, 1'b0, 1'b0);
		send_item(KIND_ALLOC, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
		send_item(KIND_MARK, 32'h0000_2ABC, 1'b0, 1'b0, 1'b1);
		send_item(KIND_ALLOC, 32'h0, 1'b0, 1'b1, 1'b0);
		send_item(KIND_MARK, 32'h00FF_E000, 1'b0, 1'b1, 1'b1);
		send_item(KIND_MARK, 32'h00FF_F000, 1'b0, 1'b0, 1'b0);
		send_item(KIND_MARK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		send_item(KIND_MARK, 32'h0000_0000, 1'b1, 1'b0, 1'b1);
		send_item(KIND_ALLOC, 32'h0, 1'b1, 1'b0, 1'b0);

		// empty search range: allocate reports full, every mark out of range
		drain_results();
		write_limit(13'd0);
		send_item(KIND_ALLOC, 32'h0, 1'b0, 1'b1, 1'b1);
		send_item(KIND_MARK, 32'h0, 1'b0, 1'b1, 1'b1);

		// count above the bitmap size clamps to the bitmap size
		drain_results();
		write_limit(13'd8191);
		send_item(KIND_MARK, 32'h00FF_F000, 1'b0, 1'b0, 1'b1);
		send_item(KIND_MARK, 32'h0100_0000, 1'b0, 1'b1, 1'b0);
		send_item(KIND_ALLOC, 32'h0, 1'b0, 1'b0, 1'b1);

		// partial word only: never allocated, but still markable
		drain_results();
		write_limit(13'd31);
		send_item(KIND_ALLOC, 32'h0, 1'b0, 1'b0, 1'b0);
		send_item(KIND_MARK, 32'h0001_E000, 1'b0, 1'b1, 1'b0);
		send_item(KIND_MARK, 32'h0001_F000, 1'b0, 1'b0, 1'b1);

		drain_results();
		write_limit(13'd4096);
		send_item(KIND_MARK, 32'h00FF_FFFF, 1'b0, 1'b1, 1'b1);

		drain_results();
		write_limit(13'd32);
		send_item(KIND_ALLOC, 32'h0, 1'b0, 1'b0, 1'b1);

		foreach (phase_limits[p]) begin
			drain_results();
			limit = (phase_limits[p] < 0) ? $urandom_range(0, 8191) : phase_limits[p];
			write_limit(limit[CNT_W-1:0]);
			eff = (limit > MAP_FRAMES) ? MAP_FRAMES : limit;
			steady_flow = (p % 4 == 2);
			repeat (PHASE_ITEMS) random_item(eff);
		end

		steady_flow = 1'b0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
